// ----- hw/rtl/lease_slot_allocator_defines.svh -----
// Assertion macros shared by the allocator RTL.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef LEASE_SLOT_ALLOCATOR_DEFINES_SVH
`define LEASE_SLOT_ALLOCATOR_DEFINES_SVH

// Condition that must hold at every clock edge out of reset.
`define LSA_ASSERT_HOLDS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define LSA_ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define LSA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/lsa_pkg.sv -----
package lsa_pkg;

	localparam logic [31:0] LEASE_RESET = 32'd100000;

	typedef enum logic [1:0] {
		MODE_ALLOC = 2'd0,
		MODE_FIND  = 2'd1,
		MODE_TICK  = 2'd2
	} lsa_mode_t;

	// One slot record as held in the slot table.
	typedef struct packed {
		logic [31:0] tag_a;
		logic [31:0] tag_b;
		logic [31:0] start;
	} lsa_slot_rec_t;

	// Port control for a one-write, one-read memory.
	typedef struct packed {
		logic rd;
		logic wr;
	} lsa_mem_ctl_t;

endpackage

// ----- hw/rtl/lsa_ifs.sv -----
interface lsa_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [6:0]  slot_id;
	logic [31:0] tag_a;
	logic [31:0] tag_b;

	modport source (output valid, mode, slot_id, tag_a, tag_b, input ready);
	modport sink (input valid, mode, slot_id, tag_a, tag_b, output ready);
endinterface

interface lsa_rsp_if;
	logic        valid;
	logic        ready;
	logic        ok;
	logic [6:0]  result_id;
	logic [31:0] found_tag_a;
	logic [31:0] found_tag_b;
	logic [31:0] found_start;
	logic [6:0]  expired_count;

	modport source (output valid, ok, result_id, found_tag_a, found_tag_b, found_start,
		expired_count, input ready);
	modport sink (input valid, ok, result_id, found_tag_a, found_tag_b, found_start,
		expired_count, output ready);
endinterface

interface lsa_cfg_if;
	logic        valid;
	logic        ready;
	logic [31:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// ----- hw/rtl/lsa_slot_table.sv -----
module lsa_slot_table import lsa_pkg::*; #(
	parameter int NUM_SLOTS = 64,
	localparam int AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
	input  logic          clk,
	input  lsa_mem_ctl_t  ctl,
	input  logic [AW-1:0] wr_addr,
	input  lsa_slot_rec_t wr_data,
	input  logic [AW-1:0] rd_addr,
	output lsa_slot_rec_t rd_data
);

	lsa_slot_rec_t mem_q [NUM_SLOTS];
	lsa_slot_rec_t rd_data_q;

	// Entries are to be read only after an allocation has written them; the table does not enforce it.
	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (ctl.rd) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- hw/rtl/lsa_free_stack.sv -----
module lsa_free_stack import lsa_pkg::*; #(
	parameter int NUM_SLOTS = 64,
	localparam int AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1,
	localparam int IDW = $clog2(NUM_SLOTS + 1)
) (
	input  logic           clk,
	input  logic           arst_n,
	input  lsa_mem_ctl_t   ctl,
	input  logic [AW-1:0]  wr_addr,
	input  logic [IDW-1:0] wr_id,
	input  logic [AW-1:0]  rd_addr,
	output logic [IDW-1:0] rd_id
);

	logic [IDW-1:0]       mem_q [NUM_SLOTS];
	logic [NUM_SLOTS-1:0] written_q;
	logic [IDW-1:0]       rd_data_q;
	logic                 rd_hit_q;
	logic [AW-1:0]        rd_addr_q;

	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			mem_q[wr_addr] <= wr_id;
		end
		if (ctl.rd) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	// A read of an entry never pushed to returns its reset ID, one above its position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
			rd_hit_q  <= 1'b0;
			rd_addr_q <= '0;
		end else begin
			if (ctl.wr) begin
				written_q[wr_addr] <= 1'b1;
			end
			if (ctl.rd) begin
				rd_hit_q  <= written_q[rd_addr];
				rd_addr_q <= rd_addr;
			end
		end
	end

	assign rd_id = rd_hit_q ? rd_data_q : (IDW'(rd_addr_q) + IDW'(1));

endmodule

// ----- hw/rtl/lease_slot_allocator.sv -----
// Channel  Dir   Beat contents
// req      in    mode, slot_id, tag_a, tag_b
// rsp      out   ok, result_id, found_tag_a, found_tag_b, found_start, expired_count
// cfg      in    data (lease length in ticks)
//
// A successful allocate passes through S_ALLOC and a find hit through S_FIND before S_DONE;
// an allocate on an empty stack, a find miss and the unused mode go straight to S_DONE.
// A tick beat makes one slot-table read per slot in S_SWEEP, then a drain in S_DRAIN.
// The sweep rate is set by the single read port of the slot table and the one age comparer.
// Reset leaves all slots free, the tick at zero and the lease at 100000; no clearing pass.
// req is not ready until the previous result has moved into the rsp register.
// A stalled rsp holds its beat; the next result waits in the sequencer until it drains.
`include "lease_slot_allocator_defines.svh"

module lease_slot_allocator import lsa_pkg::*; #(
	parameter int NUM_SLOTS = 64
) (
	input logic     clk,
	input logic     arst_n,
	lsa_req_if.sink req,
	lsa_rsp_if.source rsp,
	lsa_cfg_if.sink cfg
);

	localparam int AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int IDW = $clog2(NUM_SLOTS + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_ALLOC,
		S_FIND,
		S_SWEEP,
		S_DRAIN,
		S_DONE
	} state_t;

	state_t               state_q;
	logic [31:0]          lease_q;
	logic [31:0]          tick_q;
	logic [IDW-1:0]       free_cnt_q;
	logic [NUM_SLOTS-1:0] in_use_q;

	// Latched request fields.
	logic [6:0]           sid_q;
	logic [31:0]          tag_a_q;
	logic [31:0]          tag_b_q;

	// Sweep counter and its one-stage read pipeline.
	logic [AW-1:0]        sweep_k_q;
	logic                 sweep_v_s1;
	logic [AW-1:0]        sweep_k_s1;
	logic [IDW-1:0]       exp_cnt_q;

	// Result waiting for the output register.
	logic                 res_ok_q;
	logic [6:0]           res_id_q;
	logic [31:0]          res_tag_a_q;
	logic [31:0]          res_tag_b_q;
	logic [31:0]          res_start_q;
	logic [6:0]           res_exp_q;

	// Output register.
	logic                 rsp_valid_q;
	logic                 rsp_ok_q;
	logic [6:0]           rsp_id_q;
	logic [31:0]          rsp_tag_a_q;
	logic [31:0]          rsp_tag_b_q;
	logic [31:0]          rsp_start_q;
	logic [6:0]           rsp_exp_q;

	lsa_mem_ctl_t         stk_ctl;
	logic [AW-1:0]        stk_wr_addr;
	logic [IDW-1:0]       stk_wr_id;
	logic [AW-1:0]        stk_rd_addr;
	logic [IDW-1:0]       stk_rd_id;

	lsa_mem_ctl_t         tbl_ctl;
	logic [AW-1:0]        tbl_wr_addr;
	lsa_slot_rec_t        tbl_wr_data;
	logic [AW-1:0]        tbl_rd_addr;
	lsa_slot_rec_t        tbl_rd_data;

	logic                 req_fire;
	logic [31:0]          sid_ext;
	logic [31:0]          sid_m1;
	logic                 find_hit;
	logic [IDW-1:0]       cnt_m1;
	logic [IDW-1:0]       alloc_m1;
	logic [AW-1:0]        alloc_addr;
	logic [IDW+6:0]       alloc_id_ext;
	logic [31:0]          age;
	logic                 expire_hit;
	logic                 stk_room;
	logic                 push;
	logic [IDW-1:0]       exp_cnt_nxt;
	logic [IDW+6:0]       exp_ext;
	logic                 out_free;
	logic                 slots_balanced;

	assign req.ready = (state_q == S_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign cfg.ready = 1'b1;
	assign out_free  = !rsp_valid_q || rsp.ready;

	// Find is a hit only for an ID in range whose slot is held.
	assign sid_ext  = {25'd0, req.slot_id};
	assign sid_m1   = sid_ext - 32'd1;
	assign find_hit = (req.slot_id != 7'd0) && (sid_ext <= 32'(NUM_SLOTS))
		&& in_use_q[sid_m1[AW-1:0]];

	assign cnt_m1       = free_cnt_q - IDW'(1);
	assign alloc_m1     = stk_rd_id - IDW'(1);
	assign alloc_addr   = alloc_m1[AW-1:0];
	assign alloc_id_ext = {7'd0, stk_rd_id};

	// The one age comparer: a slot expires once tick - start, modulo 2^32, reaches the lease.
	assign age         = tick_q - tbl_rd_data.start;
	assign expire_hit  = sweep_v_s1 && in_use_q[sweep_k_s1] && (age >= lease_q);
	assign stk_room    = int'(free_cnt_q) < NUM_SLOTS;
	assign push        = expire_hit && stk_room;
	assign exp_cnt_nxt = exp_cnt_q + IDW'(expire_hit);
	assign exp_ext     = {7'd0, exp_cnt_nxt};

	// Every slot is counted exactly once, as held or as free.
	assign slots_balanced = ($countones(in_use_q) + int'(free_cnt_q)) == NUM_SLOTS;

	always_comb begin
		stk_ctl     = '0;
		stk_rd_addr = cnt_m1[AW-1:0];
		stk_wr_addr = free_cnt_q[AW-1:0];
		stk_wr_id   = IDW'(sweep_k_s1) + IDW'(1);
		tbl_ctl     = '0;
		tbl_rd_addr = sid_m1[AW-1:0];
		tbl_wr_addr = alloc_addr;
		tbl_wr_data = '{tag_a: tag_a_q, tag_b: tag_b_q, start: tick_q};
		if (req_fire) begin
			case (lsa_mode_t'(req.mode))
				MODE_ALLOC: stk_ctl.rd = (free_cnt_q != '0);
				MODE_FIND:  tbl_ctl.rd = find_hit;
				default: ;
			endcase
		end
		if (state_q == S_ALLOC) begin
			tbl_ctl.wr = 1'b1;
		end
		if (state_q == S_SWEEP) begin
			tbl_ctl.rd  = 1'b1;
			tbl_rd_addr = sweep_k_q;
		end
		stk_ctl.wr = push;
	end

	lsa_free_stack #(.NUM_SLOTS(NUM_SLOTS)) u_free_stack (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (stk_ctl),
		.wr_addr (stk_wr_addr),
		.wr_id   (stk_wr_id),
		.rd_addr (stk_rd_addr),
		.rd_id   (stk_rd_id)
	);

	lsa_slot_table #(.NUM_SLOTS(NUM_SLOTS)) u_slot_table (
		.clk     (clk),
		.ctl     (tbl_ctl),
		.wr_addr (tbl_wr_addr),
		.wr_data (tbl_wr_data),
		.rd_addr (tbl_rd_addr),
		.rd_data (tbl_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			lease_q     <= LEASE_RESET;
			tick_q      <= '0;
			free_cnt_q  <= IDW'(NUM_SLOTS);
			in_use_q    <= '0;
			sid_q       <= '0;
			tag_a_q     <= '0;
			tag_b_q     <= '0;
			sweep_k_q   <= '0;
			sweep_v_s1  <= 1'b0;
			sweep_k_s1  <= '0;
			exp_cnt_q   <= '0;
			res_ok_q    <= 1'b0;
			res_id_q    <= '0;
			res_tag_a_q <= '0;
			res_tag_b_q <= '0;
			res_start_q <= '0;
			res_exp_q   <= '0;
			rsp_valid_q <= 1'b0;
			rsp_ok_q    <= 1'b0;
			rsp_id_q    <= '0;
			rsp_tag_a_q <= '0;
			rsp_tag_b_q <= '0;
			rsp_start_q <= '0;
			rsp_exp_q   <= '0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				lease_q <= cfg.data;
			end
			if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end

			// The sweep's read stage checks one slot per cycle and retires it if it has expired.
			if (expire_hit) begin
				in_use_q[sweep_k_s1] <= 1'b0;
			end
			if (push) begin
				free_cnt_q <= free_cnt_q + IDW'(1);
			end
			exp_cnt_q <= exp_cnt_nxt;

			case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						sid_q       <= req.slot_id;
						tag_a_q     <= req.tag_a;
						tag_b_q     <= req.tag_b;
						res_ok_q    <= 1'b0;
						res_id_q    <= '0;
						res_tag_a_q <= '0;
						res_tag_b_q <= '0;
						res_start_q <= '0;
						res_exp_q   <= '0;
						state_q     <= S_DONE;
						case (lsa_mode_t'(req.mode))
							MODE_ALLOC: begin
								if (free_cnt_q != '0) begin
									state_q <= S_ALLOC;
								end
							end
							MODE_FIND: begin
								if (find_hit) begin
									state_q <= S_FIND;
								end
							end
							MODE_TICK: begin
								tick_q    <= tick_q + 32'd1;
								sweep_k_q <= '0;
								exp_cnt_q <= '0;
								state_q   <= S_SWEEP;
							end
							default: ;
						endcase
					end
				end
				S_ALLOC: begin
					free_cnt_q           <= cnt_m1;
					in_use_q[alloc_addr] <= 1'b1;
					res_ok_q             <= 1'b1;
					res_id_q             <= alloc_id_ext[6:0];
					state_q              <= S_DONE;
				end
				S_FIND: begin
					res_ok_q    <= 1'b1;
					res_id_q    <= sid_q;
					res_tag_a_q <= tbl_rd_data.tag_a;
					res_tag_b_q <= tbl_rd_data.tag_b;
					res_start_q <= tbl_rd_data.start;
					state_q     <= S_DONE;
				end
				S_SWEEP: begin
					sweep_v_s1 <= 1'b1;
					sweep_k_s1 <= sweep_k_q;
					if (sweep_k_q == AW'(NUM_SLOTS - 1)) begin
						state_q <= S_DRAIN;
					end else begin
						sweep_k_q <= sweep_k_q + AW'(1);
					end
				end
				S_DRAIN: begin
					sweep_v_s1 <= 1'b0;
					res_exp_q  <= exp_ext[6:0];
					state_q    <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						rsp_valid_q <= 1'b1;
						rsp_ok_q    <= res_ok_q;
						rsp_id_q    <= res_id_q;
						rsp_tag_a_q <= res_tag_a_q;
						rsp_tag_b_q <= res_tag_b_q;
						rsp_start_q <= res_start_q;
						rsp_exp_q   <= res_exp_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.ok            = rsp_ok_q;
	assign rsp.result_id     = rsp_id_q;
	assign rsp.found_tag_a   = rsp_tag_a_q;
	assign rsp.found_tag_b   = rsp_tag_b_q;
	assign rsp.found_start   = rsp_start_q;
	assign rsp.expired_count = rsp_exp_q;

	// Every slot is either held or on the free stack, never both.
	`LSA_ASSERT_HOLDS(a_slot_conservation, slots_balanced, "held and free slot counts disagree")
	// A sweep never pushes onto a full stack.
	`LSA_ASSERT_IMPLIES(a_push_room, expire_hit, stk_room, "expired slot hit a full free stack")
	// Once a beat is taken the sequencer is not ready in the cycle after.
	`LSA_ASSERT_NEXT(a_busy_after_accept, req_fire, !req.ready, "busy sequencer still ready")
	// A successful allocate or find never reports expirations.
	`LSA_ASSERT_IMPLIES(a_ok_no_expire, rsp_ok_q, rsp_exp_q == '0, "ok result with expirations")

endmodule
